// ===== hdl/lkvc_pkg.sv =====
// Shared constants and types for the LRU key/value cache.
`default_nettype none

package lkvc_pkg;

   localparam int ENTRIES = 16;
   localparam int KEY_W   = 32;
   localparam int VALUE_W = 32;
   localparam int CAP_W   = 5;
   localparam int CNT_W   = $clog2(ENTRIES + 1);
   localparam int CMP_W   = (CAP_W > CNT_W) ? CAP_W : CNT_W;

   localparam logic [CAP_W-1:0]   CAP_RESET  = CAP_W'(16);
   localparam logic [VALUE_W-1:0] MISS_VALUE = '1;

   localparam logic MODE_GET = 1'b0;
   localparam logic MODE_PUT = 1'b1;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_SHIFT,
      CELL_DROP
   } cell_cmd_type;

   typedef struct packed {
      logic               valid;
      logic [KEY_W-1:0]   key;
      logic [VALUE_W-1:0] value;
   } entry_type;

endpackage

`default_nettype wire

// ===== hdl/lkvc_cell.sv =====
// One recency slot of the cache: holds an entry, matches its key, and moves data down the row.
`default_nettype none

module lkvc_cell (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire lkvc_pkg::cell_cmd_type    cmd,
   input  wire lkvc_pkg::entry_type       prev_entry,
   input  wire logic [lkvc_pkg::KEY_W-1:0] probe_key,
   output lkvc_pkg::entry_type            entry,
   output logic                           match
);
   import lkvc_pkg::*;

   logic               valid_ff, valid_in;
   logic [KEY_W-1:0]   key_ff, key_in;
   logic [VALUE_W-1:0] value_ff, value_in;

   always_comb begin
      valid_in = valid_ff;
      key_in   = key_ff;
      value_in = value_ff;
      case (cmd)
         CELL_SHIFT: begin
            valid_in = prev_entry.valid;
            key_in   = prev_entry.key;
            value_in = prev_entry.value;
         end
         CELL_DROP: begin
            valid_in = 1'b0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      key_ff   <= key_in;
      value_ff <= value_in;
   end

   assign match = valid_ff && (key_ff == probe_key);

   always_comb begin
      entry.valid = valid_ff;
      entry.key   = key_ff;
      entry.value = value_ff;
   end

endmodule

`default_nettype wire

// ===== hdl/lru_key_value_cache.sv =====
// Top level of the fully associative LRU key/value cache built as a row of recency cells.
`default_nettype none

// The cache takes one item per clock: busy is high during reset and only in the first
// cycle after it, and a get returns its result on rsp_valid in the cycle right after the
// transfer, so results follow items back to back. The receiver cannot stall; every
// strobed result must be taken in its one cycle. Entries sit in a row of cells ordered
// by recency, most recent at the head, and all keys are compared at once; a hit moves
// its entry to the head, and a new key enters at the head while the entries at and
// beyond the capacity fall off the tail. Lowering the capacity takes effect at the
// next insertion of a new key.
module lru_key_value_cache (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic                          req_mode,
   input  wire logic signed [lkvc_pkg::KEY_W-1:0]   req_lookup_key,
   input  wire logic signed [lkvc_pkg::VALUE_W-1:0] req_write_value,
   output logic                               rsp_valid,
   output logic                               rsp_found,
   output logic signed [lkvc_pkg::VALUE_W-1:0] rsp_read_value,
   input  wire logic                          csr_write_enable,
   input  wire logic [lkvc_pkg::CAP_W-1:0]    csr_write_data
);
   import lkvc_pkg::*;

   logic                 busy_ff;
   logic [CAP_W-1:0]     cap_ff, cap_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_found_ff, rsp_found_in;
   logic [VALUE_W-1:0]   rsp_value_ff, rsp_value_in;

   logic                 accept;
   logic [CMP_W-1:0]     cap_eff;
   logic [ENTRIES-1:0]   match;
   logic [ENTRIES-1:0]   hit_from;
   logic                 hit_any;
   logic [VALUE_W-1:0]   hit_value;
   entry_type            head;
   entry_type            cells [ENTRIES];
   cell_cmd_type         cmds [ENTRIES];

   assign accept  = start && !busy_ff;
   assign hit_any = |match;

   // Clamp the capacity register to between one and the storage that exists.
   always_comb begin
      cap_eff = CMP_W'(cap_ff);
      if (cap_eff == '0) begin
         cap_eff = CMP_W'(1);
      end else if (cap_eff > CMP_W'(ENTRIES)) begin
         cap_eff = CMP_W'(ENTRIES);
      end
   end

   always_comb begin
      hit_value = '0;
      for (int k = 0; k < ENTRIES; k++) begin
         hit_value = hit_value | (match[k] ? cells[k].value : '0);
      end
   end

   always_comb begin
      head.valid = 1'b1;
      head.key   = req_lookup_key;
      head.value = (req_mode == MODE_PUT) ? req_write_value : hit_value;
   end

   genvar i;
   generate
      for (i = 0; i < ENTRIES; i++) begin : g_cell
         entry_type prev;

         // A hit at this slot or further down the row pulls this slot one step down.
         assign hit_from[i] = |match[ENTRIES-1:i];

         always_comb begin
            cmds[i] = CELL_HOLD;
            if (accept) begin
               if (hit_any) begin
                  cmds[i] = hit_from[i] ? CELL_SHIFT : CELL_HOLD;
               end else if (req_mode == MODE_PUT) begin
                  cmds[i] = (CMP_W'(i) < cap_eff) ? CELL_SHIFT : CELL_DROP;
               end
            end
         end

         if (i == 0) begin : g_head
            assign prev = head;
         end else begin : g_body
            assign prev = cells[i-1];
         end

         lkvc_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .cmd        (cmds[i]),
            .prev_entry (prev),
            .probe_key  (req_lookup_key),
            .entry      (cells[i]),
            .match      (match[i])
         );
      end
   endgenerate

   always_comb begin
      cap_in       = csr_write_enable ? csr_write_data : cap_ff;
      rsp_valid_in = accept && (req_mode == MODE_GET);
      rsp_found_in = hit_any;
      rsp_value_in = hit_any ? hit_value : MISS_VALUE;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b1;
         cap_ff       <= CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= 1'b0;
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_found_ff <= rsp_found_in;
      rsp_value_ff <= rsp_value_in;
   end

   assign busy           = busy_ff;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_found      = rsp_found_ff;
   assign rsp_read_value = rsp_value_ff;

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
// Self-checking testbench for the LRU key/value cache: directed and random access traffic.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import lkvc_pkg::*;

   typedef struct {
      logic               found;
      logic [VALUE_W-1:0] read_value;
   } lookup_result_type;

   logic clock;
   logic reset;
   logic start;
   logic busy;
   logic req_mode;
   logic signed [KEY_W-1:0]   req_lookup_key;
   logic signed [VALUE_W-1:0] req_write_value;
   logic rsp_valid;
   logic rsp_found;
   logic signed [VALUE_W-1:0] rsp_read_value;
   logic csr_write_enable;
   logic [CAP_W-1:0] csr_write_data;

   // Mirror of the cache contents, kept in step with every accepted transfer.
   logic               model_valid [ENTRIES];
   logic [KEY_W-1:0]   model_key   [ENTRIES];
   logic [VALUE_W-1:0] model_value [ENTRIES];
   int                 model_rank  [ENTRIES];
   int                 model_count;
   logic [CAP_W-1:0]   model_capacity;

   lookup_result_type pending_lookups[$];
   lookup_result_type oldest_lookup;
   int             mismatch_count;
   logic [KEY_W-1:0] key_pool [40];

   lru_key_value_cache dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_mode        (req_mode),
      .req_lookup_key  (req_lookup_key),
      .req_write_value (req_write_value),
      .rsp_valid       (rsp_valid),
      .rsp_found       (rsp_found),
      .rsp_read_value  (rsp_read_value),
      .csr_write_enable(csr_write_enable),
      .csr_write_data  (csr_write_data)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   initial begin
      #2ms;
      $display("CHECK FAILED");
      $finish;
   end

   // Entries more recent than the touched one age by one; the touched one becomes rank 0.
   function automatic void promote_entry(int slot);
      int old_rank;
      old_rank = model_rank[slot];
      for (int i = 0; i < ENTRIES; i++) begin
         if (model_valid[i] && model_rank[i] < old_rank) model_rank[i]++;
      end
      model_rank[slot] = 0;
   endfunction

   function automatic void evict_least_recent();
      int victim;
      victim = -1;
      for (int i = 0; i < ENTRIES; i++) begin
         if (model_valid[i] && (victim < 0 || model_rank[i] > model_rank[victim])) victim = i;
      end
      if (victim >= 0) begin
         model_valid[victim] = 1'b0;
         model_rank[victim] = 0;
         if (model_count > 0) model_count--;
      end
   endfunction

   function automatic void predict_cache_access(logic mode, logic [KEY_W-1:0] key,
                                                logic [VALUE_W-1:0] value);
      int slot;
      int free_slot;
      int usable;
      lookup_result_type outcome;
      slot = -1;
      for (int i = 0; i < ENTRIES; i++) begin
         if (model_valid[i] && model_key[i] == key) slot = i;
      end
      if (mode == MODE_GET) begin
         if (slot >= 0) begin
            outcome.found = 1'b1;
            outcome.read_value = model_value[slot];
            promote_entry(slot);
         end else begin
            outcome.found = 1'b0;
            outcome.read_value = MISS_VALUE;
         end
         pending_lookups.push_back(outcome);
         return;
      end
      if (slot >= 0) begin
         model_value[slot] = value;
         promote_entry(slot);
         return;
      end
      usable = int'(model_capacity);
      if (usable < 1) usable = 1;
      if (usable > ENTRIES) usable = ENTRIES;
      while (model_count >= usable && model_count > 0) evict_least_recent();
      free_slot = -1;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (!model_valid[i]) free_slot = i;
      end
      if (free_slot < 0) return;
      for (int i = 0; i < ENTRIES; i++) begin
         if (model_valid[i]) model_rank[i]++;
      end
      model_valid[free_slot] = 1'b1;
      model_key[free_slot] = key;
      model_value[free_slot] = value;
      model_rank[free_slot] = 0;
      model_count++;
   endfunction

   // Results come in the cycle after the transfer, so expectations are queued at the
   // falling edge that follows it.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_lookups.size() == 0) begin
            $error("unexpected result: found %0d read_value %h", rsp_found, rsp_read_value);
            mismatch_count++;
         end else begin
            oldest_lookup = pending_lookups.pop_front();
            if (rsp_found !== oldest_lookup.found) begin
               $error("found: expected %0d, actual %0d", oldest_lookup.found, rsp_found);
               mismatch_count++;
            end
            if (rsp_read_value !== oldest_lookup.read_value) begin
               $error("read_value: expected %h, actual %h",
                      oldest_lookup.read_value, rsp_read_value);
               mismatch_count++;
            end
         end
      end
   end

   // Called and returning at a falling edge; start is left high for a following transfer.
   task automatic send_access(logic mode, logic [KEY_W-1:0] key, logic [VALUE_W-1:0] value);
      start = 1'b1;
      req_mode = mode;
      req_lookup_key = key;
      req_write_value = value;
      forever begin
         @(posedge clock);
         if (!busy) break;
      end
      @(negedge clock);
      predict_cache_access(mode, key, value);
   endtask

   task automatic hold_off(int cycles);
      start = 1'b0;
      repeat (cycles) @(negedge clock);
   endtask

   task automatic wait_until_drained();
      start = 1'b0;
      while (pending_lookups.size() != 0) @(negedge clock);
      // A put may still be in flight after the last lookup result.
      repeat (4) @(negedge clock);
   endtask

   task automatic write_capacity(logic [CAP_W-1:0] capacity);
      wait_until_drained();
      csr_write_enable = 1'b1;
      csr_write_data = capacity;
      @(negedge clock);
      csr_write_enable = 1'b0;
      model_capacity = capacity;
   endtask

   task automatic test_directed_access();
      send_access(MODE_GET, 32'h0000_0000, $urandom);
      send_access(MODE_PUT, 32'h0000_0000, 32'h0000_0000);
      send_access(MODE_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
      send_access(MODE_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
      send_access(MODE_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_access(MODE_GET, 32'h0000_0000, $urandom);
      send_access(MODE_GET, 32'h8000_0000, $urandom);
      send_access(MODE_GET, 32'h7FFF_FFFF, $urandom);
      // A stored all-ones value must still come back with found set.
      send_access(MODE_GET, 32'hFFFF_FFFF, $urandom);
      send_access(MODE_PUT, 32'h0000_0000, 32'h1234_5678);
      send_access(MODE_GET, 32'h0000_0000, $urandom);
      send_access(MODE_GET, 32'h0000_0001, $urandom);
   endtask

   task automatic test_capacity_limits();
      // Four entries are held, so the next new key trims the table down to one first.
      write_capacity(5'd2);
      send_access(MODE_PUT, 32'h0000_AAAA, 32'h0A0A_0A0A);
      send_access(MODE_GET, 32'h0000_0000, $urandom);
      send_access(MODE_GET, 32'hFFFF_FFFF, $urandom);
      send_access(MODE_PUT, 32'h0000_BBBB, 32'h0B0B_0B0B);
      send_access(MODE_GET, 32'h0000_AAAA, $urandom);
      // A capacity of zero behaves as one.
      write_capacity(5'd0);
      send_access(MODE_PUT, 32'h0000_CCCC, 32'h0C0C_0C0C);
      send_access(MODE_GET, 32'h0000_BBBB, $urandom);
      send_access(MODE_GET, 32'h0000_CCCC, $urandom);
   endtask

   task automatic test_random_traffic();
      logic [CAP_W-1:0] phase_capacity [10];
      int pool_span;
      int put_percent;
      int burst_left;
      int pick;
      logic [KEY_W-1:0] key;
      phase_capacity = '{5'd16, 5'd1, 5'd31, 5'd0, 5'd17, 5'd8,
                         5'd0, 5'd0, 5'd0, 5'd0};
      for (int p = 6; p < 10; p++) phase_capacity[p] = CAP_W'($urandom_range(0, 31));
      for (int i = 0; i < 40; i++) key_pool[i] = $urandom;
      burst_left = 0;
      for (int p = 0; p < 10; p++) begin
         write_capacity(phase_capacity[p]);
         pool_span = $urandom_range(1, 40);
         put_percent = $urandom_range(30, 70);
         for (int n = 0; n < 155; n++) begin
            if (burst_left == 0) begin
               hold_off($urandom_range(0, 6));
               burst_left = $urandom_range(1, 40);
            end
            burst_left--;
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
               key = $urandom;
            end else if (pick < 11) begin
               case ($urandom_range(0, 3))
                  0: key = 32'h0000_0000;
                  1: key = 32'h7FFF_FFFF;
                  2: key = 32'h8000_0000;
                  default: key = 32'hFFFF_FFFF;
               endcase
            end else begin
               key = key_pool[$urandom_range(0, pool_span - 1)];
            end
            send_access(($urandom_range(0, 99) < put_percent) ? MODE_PUT : MODE_GET,
                        key, $urandom);
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_mode = MODE_GET;
      req_lookup_key = '0;
      req_write_value = '0;
      csr_write_enable = 1'b0;
      csr_write_data = '0;
      mismatch_count = 0;
      model_count = 0;
      model_capacity = CAP_RESET;
      for (int i = 0; i < ENTRIES; i++) begin
         model_valid[i] = 1'b0;
         model_key[i] = '0;
         model_value[i] = '0;
         model_rank[i] = 0;
      end
      repeat (5) @(negedge clock);
      reset = 1'b0;

      test_directed_access();
      test_capacity_limits();
      test_random_traffic();

      wait_until_drained();
      if (pending_lookups.size() != 0) begin
         $error("%0d expected results never arrived", pending_lookups.size());
         mismatch_count++;
      end
      if (mismatch_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
hdl/lkvc_pkg.sv
hdl/lkvc_cell.sv
hdl/lru_key_value_cache.sv
sim/testbench.sv
